// File: src/pcxr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxr_pkg
// Shared types and constants for the PCX 1bpp run-length line decoder.
// ----------------------------------------------------------------------------
package pcxr_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd2;

  localparam logic [15:0] LINE_WIDTH_RST = 16'd8;
  localparam logic [15:0] LINE_BYTES_RST = 16'd1;
  localparam logic [15:0] IMAGE_ROWS_RST = 16'd1;

  localparam logic [1:0] RUN_TAG  = 2'b11;
  localparam logic [5:0] RUN_MASK = 6'h3F;
  localparam logic [3:0] PIX_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [15:0] line_width;
    logic [15:0] line_bytes;
    logic [15:0] image_rows;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  bits;
    logic [3:0]  cnt;
    logic [15:0] fcol;
    logic        eor;
    logic        eoi;
  } place_res_t;

endpackage

// File: src/pcx_rle_mono_line_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_mono_line_decoder_top
// PCX run-length decoder for 1bpp scan lines, one code byte per transaction.
// The taken byte is registered in value_r and each result in the output
// registers; a marker byte or zero run emits none. Input is not taken while
// a literal or run is emitted; emission waits while the output is full.
// Reset: synchronous active low; config back to 8/1/1, decode state cleared.
// ----------------------------------------------------------------------------
module pcx_rle_mono_line_decoder_top
  import pcxr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_code_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_pixel_bits,
  output logic [3:0]           out_pixel_count,
  output logic [15:0]          out_row_index,
  output logic [15:0]          out_first_column,
  output logic                 out_end_of_row,
  output logic                 out_end_of_image,
  output logic                 out_last_of_run,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t      state_r, state_nxt;
  cfg_t        cfg_r, cfg_nxt;
  logic        awaiting_r, awaiting_nxt;
  logic [5:0]  pending_r, pending_nxt;
  logic [5:0]  reps_r, reps_nxt;
  logic [7:0]  value_r, value_nxt;
  logic [15:0] bil_r, bil_nxt;
  logic [15:0] row_r, row_nxt;
  logic        done_r, done_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [7:0]  obits_r, obits_nxt;
  logic [3:0]  ocnt_r, ocnt_nxt;
  logic [15:0] orow_r, orow_nxt;
  logic [15:0] ocol_r, ocol_nxt;
  logic        oeor_r, oeor_nxt;
  logic        oeoi_r, oeoi_nxt;
  logic        olast_r, olast_nxt;

  place_res_t  pres;
  logic        in_acc;
  logic        slot_free;
  logic        last;

  pcxr_place u_place (
    .cfg           (cfg_r),
    .bytes_in_line (bil_r),
    .current_row   (row_r),
    .value         (value_r),
    .res           (pres)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !ovalid_r || out_ready;
  assign last      = (reps_r == 6'd1) || pres.eor;

  always_comb begin
    state_nxt    = state_r;
    cfg_nxt      = cfg_r;
    awaiting_nxt = awaiting_r;
    pending_nxt  = pending_r;
    reps_nxt     = reps_r;
    value_nxt    = value_r;
    bil_nxt      = bil_r;
    row_nxt      = row_r;
    done_nxt     = done_r;
    ovalid_nxt   = ovalid_r && !out_ready;
    obits_nxt    = obits_r;
    ocnt_nxt     = ocnt_r;
    orow_nxt     = orow_r;
    ocol_nxt     = ocol_r;
    oeor_nxt     = oeor_r;
    oeoi_nxt     = oeoi_r;
    olast_nxt    = olast_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH: cfg_nxt.line_width = cfg_data;
        CFG_LINE_BYTES: cfg_nxt.line_bytes = cfg_data;
        CFG_IMAGE_ROWS: cfg_nxt.image_rows = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && !done_r) begin
          value_nxt = in_code_byte;
          if (awaiting_r) begin
            awaiting_nxt = 1'b0;
            pending_nxt  = 6'd0;
            reps_nxt     = pending_r;
            if (pending_r != 6'd0) begin
              state_nxt = ST_EMIT;
            end
          end else if (in_code_byte[7:6] == RUN_TAG) begin
            awaiting_nxt = 1'b1;
            pending_nxt  = in_code_byte[5:0] & RUN_MASK;
          end else begin
            reps_nxt  = 6'd1;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          obits_nxt  = pres.bits;
          ocnt_nxt   = pres.cnt;
          orow_nxt   = row_r;
          ocol_nxt   = pres.fcol;
          oeor_nxt   = pres.eor;
          oeoi_nxt   = pres.eoi;
          olast_nxt  = last;
          reps_nxt   = reps_r - 6'd1;
          if (pres.eor) begin
            bil_nxt = 16'd0;
            if (pres.eoi) begin
              done_nxt = 1'b1;
            end else begin
              row_nxt = row_r + 16'd1;
            end
          end else begin
            bil_nxt = bil_r + 16'd1;
          end
          if (last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      cfg_r.line_width <= LINE_WIDTH_RST;
      cfg_r.line_bytes <= LINE_BYTES_RST;
      cfg_r.image_rows <= IMAGE_ROWS_RST;
      awaiting_r       <= 1'b0;
      pending_r        <= 6'd0;
      reps_r           <= 6'd0;
      bil_r            <= 16'd0;
      row_r            <= 16'd0;
      done_r           <= 1'b0;
      ovalid_r         <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cfg_r      <= cfg_nxt;
      awaiting_r <= awaiting_nxt;
      pending_r  <= pending_nxt;
      reps_r     <= reps_nxt;
      bil_r      <= bil_nxt;
      row_r      <= row_nxt;
      done_r     <= done_nxt;
      ovalid_r   <= ovalid_nxt;
    end
    value_r <= value_nxt;
    obits_r <= obits_nxt;
    ocnt_r  <= ocnt_nxt;
    orow_r  <= orow_nxt;
    ocol_r  <= ocol_nxt;
    oeor_r  <= oeor_nxt;
    oeoi_r  <= oeoi_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_pixel_bits   = obits_r;
  assign out_pixel_count  = ocnt_r;
  assign out_row_index    = orow_r;
  assign out_first_column = ocol_r;
  assign out_end_of_row   = oeor_r;
  assign out_end_of_image = oeoi_r;
  assign out_last_of_run  = olast_r;

  // end of image also closes the row and the run
  a_eoi_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_image |-> out_end_of_row && out_last_of_run)
    else $error("end_of_image without end_of_row / last_of_run");

  // padding results carry no pixels
  a_pad_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pixel_count == 4'd0) |-> (out_pixel_bits == 8'd0))
    else $error("padding result with pixel bits set");

  // the emit loop stops once the image is done
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == ST_IDLE))
    else $error("emitting after end of image");

  // a run in flight never waits for its value byte
  a_emit_no_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !awaiting_r && (reps_r != 6'd0))
    else $error("emit state with empty run");

endmodule

// File: src/pcxr_place.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxr_place
// Places one decoded byte in the current scan line: pixel mask, valid count,
// first column and line / image end flags.
// ----------------------------------------------------------------------------
module pcxr_place
  import pcxr_pkg::*;
(
  input  cfg_t        cfg,
  input  logic [15:0] bytes_in_line,
  input  logic [15:0] current_row,
  input  logic [7:0]  value,
  output place_res_t  res
);

  logic [18:0] col;
  logic        in_line;
  logic [15:0] diff;
  logic [3:0]  cnt;
  logic [16:0] bil_inc;
  logic [16:0] row_inc;

  always_comb begin
    col     = {bytes_in_line, 3'b000};
    in_line = col < {3'b000, cfg.line_width};
    diff    = cfg.line_width - col[15:0];
    if (!in_line) begin
      cnt = 4'd0;
    end else if (diff > {12'd0, PIX_PER_BYTE}) begin
      cnt = PIX_PER_BYTE;
    end else begin
      cnt = diff[3:0];
    end
    bil_inc = {1'b0, bytes_in_line} + 17'd1;
    row_inc = {1'b0, current_row} + 17'd1;

    res.cnt  = cnt;
    res.bits = value & ~(8'hFF >> cnt);
    res.fcol = in_line ? col[15:0] : cfg.line_width;
    res.eor  = bil_inc >= {1'b0, cfg.line_bytes};
    res.eoi  = res.eor && (row_inc >= {1'b0, cfg.image_rows});
  end

endmodule
